/* rtl/core/epdr_pkg.sv */
// Shared widths, codes and helpers for the eased PWM duty ramp unit.
package epdr_pkg;

  // Fixed-point and field widths
  localparam int FRAC_W  = 16;
  localparam int DUTY_W  = 23;
  localparam int NORM_W  = FRAC_W + 1;
  localparam int RMS_W   = 17;
  localparam int TIME_W  = 32;
  localparam int LEN_W   = 16;
  localparam int COUNT_W = 16;
  localparam int RES_W   = 5;
  localparam int MAX_RES = 16;

  // One in Q.FRAC_W, and the count divisor left after dropping the fraction bits
  localparam logic [NORM_W-1:0] ONE_Q   = NORM_W'(1) << FRAC_W;
  localparam logic [LEN_W-1:0]  PCT_DEN = LEN_W'(100);

  // Serial multiplier: 24-bit multiplicand, 17-bit multiplier
  localparam int MUL_A_W   = DUTY_W + 1;
  localparam int MUL_B_W   = NORM_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  // Serial divider: 24-bit dividend, 16-bit divisor
  localparam int DIV_N_W   = 24;
  localparam int DIV_D_W   = LEN_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // Port widths
  localparam int TDATA_IN_W  = 96;
  localparam int TUSER_IN_W  = 2;
  localparam int TDATA_OUT_W = 40;
  localparam int TUSER_OUT_W = 2;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  // Command codes
  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SET_VALUE = 2'd1,
    CMD_SET_DUTY  = 2'd2,
    CMD_STOP      = 2'd3
  } cmd_e;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_MIN_DUTY = 2'd0,
    REG_MAX_DUTY = 2'd1,
    REG_RES_BITS = 2'd2,
    REG_DEF_RAMP = 2'd3
  } reg_e;

  // Clamp signed x to min..max; if bounds cross, x below min gives min, else max
  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [DUTY_W+1:0] x,
                                                   input logic [DUTY_W-1:0] lo,
                                                   input logic [DUTY_W-1:0] hi);
    logic [DUTY_W-1:0] r;
    if (x < $signed({2'b00, lo})) begin
      r = lo;
    end else if (x > $signed({2'b00, hi})) begin
      r = hi;
    end else begin
      r = x[DUTY_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/epdr_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module epdr_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [epdr_pkg::MUL_A_W-1:0]  a_i,
  input  logic [epdr_pkg::MUL_B_W-1:0]  b_i,
  output logic                          done_o,
  output logic [epdr_pkg::PROD_W-1:0]   prod_o
);
  import epdr_pkg::*;

  logic [MUL_A_W-1:0]   a_q;
  logic [MUL_A_W-1:0]   hi_q, hi_d;
  logic [MUL_B_W-1:0]   lo_q, lo_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MUL_A_W:0]     sum;

  // Add the multiplicand when the low bit is set, then shift right
  always_comb begin
    sum    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d   = '0;
      lo_d   = b_i;
      cnt_d  = MUL_CNT_W'(MUL_B_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d   = sum[MUL_A_W:1];
      lo_d   = {sum[0], lo_q[MUL_B_W-1:1]};
      cnt_d  = cnt_q - MUL_CNT_W'(1);
      busy_d = (cnt_q != MUL_CNT_W'(1));
      done_d = (cnt_q == MUL_CNT_W'(1));
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Hold operand and partial product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

/* rtl/core/epdr_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module epdr_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [epdr_pkg::DIV_CNT_W-1:0]  steps_i,
  input  logic [epdr_pkg::DIV_D_W-1:0]    rem_i,
  input  logic [epdr_pkg::DIV_N_W-1:0]    num_i,
  input  logic [epdr_pkg::DIV_D_W-1:0]    den_i,
  output logic                            done_o,
  output logic [epdr_pkg::DIV_N_W-1:0]    quo_o
);
  import epdr_pkg::*;

  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_N_W-1:0]   num_q, num_d;
  logic [DIV_D_W-1:0]   den_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W:0]     trial;
  logic                 ge;

  // Shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    shifted = {rem_q, num_q[DIV_N_W-1]};
    trial   = shifted - {1'b0, den_q};
    ge      = (shifted >= {1'b0, den_q});
    rem_d   = rem_q;
    num_d   = num_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = rem_i;
      num_d  = num_i;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
      num_d  = {num_q[DIV_N_W-2:0], ge};
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      busy_d = (cnt_q != DIV_CNT_W'(1));
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Hold divisor, remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
    end
    rem_q <= rem_d;
    num_q <= num_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

/* rtl/core/eased_pwm_duty_ramp_unit.sv */
// Top level of the eased PWM duty ramp unit: sequencer, state and ports.
//
//  Channel  | Direction | Handshake               | Contents
//  s_axis   | in        | tvalid/tready           | command request (tuser), operands (tdata)
//  m_axis   | out       | tvalid/tready           | flags (tuser), count/duty/ramping (tdata)
//  apb      | in        | psel/penable/pwrite     | min/max duty, resolution, default ramp
//
//  One request at a time. Every request ends with a 17-step serial multiply and
//  a 24-step serial divide for the count; set-value adds one multiply, and a tick
//  inside a ramp adds a 16-step divide and two multiplies before the count.
//  The result sits in an output register, so a new request is taken while it waits.
//  Reset clears the duty state and loads the register defaults; no clearing pass.
module eased_pwm_duty_ramp_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: norm_value[16:0], duty_request[39:17], ramp_ms[56:40], now_ms[88:57]
  input  logic [epdr_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  // tuser: command[1:0]
  input  logic [epdr_pkg::TUSER_IN_W-1:0]    s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: duty_count[15:0], current_duty[38:16], ramping[39]
  output logic [epdr_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  // tuser: accepted[0], duty_written[1]
  output logic [epdr_pkg::TUSER_OUT_W-1:0]   m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [epdr_pkg::PADDR_W-1:0]       paddr,
  input  logic [epdr_pkg::PDATA_W-1:0]       pwdata,
  output logic [epdr_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);
  import epdr_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DISPATCH = 9'b000000010,
    ST_DIV_T    = 9'b000000100,
    ST_MUL_E    = 9'b000001000,
    ST_MUL_S    = 9'b000010000,
    ST_MUL_V    = 9'b000100000,
    ST_COUNT    = 9'b001000000,
    ST_MUL_C    = 9'b010000000,
    ST_DIV_C    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [DUTY_W-1:0] min_duty_q, max_duty_q;
  logic [RES_W-1:0]  res_bits_q;
  logic [LEN_W-1:0]  def_ramp_q;

  // Duty and ramp state
  logic [DUTY_W-1:0] duty_now_q, duty_now_d;
  logic [DUTY_W-1:0] duty_goal_q, duty_goal_d;
  logic [TIME_W-1:0] ramp_start_q, ramp_start_d;
  logic [LEN_W-1:0]  ramp_length_q, ramp_length_d;
  logic              ramp_active_q, ramp_active_d;

  // Captured request
  cmd_e              cmd_q;
  logic [NORM_W-1:0] norm_q;
  logic [DUTY_W-1:0] req_q;
  logic [RMS_W-1:0]  rms_q;
  logic [TIME_W-1:0] now_q;

  // Work registers
  logic               written_q, written_d;
  logic               neg_q, neg_d;
  logic               ease_lo_q, ease_lo_d;
  logic [COUNT_W-1:0] count_q, count_d;

  // Output register
  logic                   m_valid_q;
  logic [TDATA_OUT_W-1:0] m_data_q;
  logic [TUSER_OUT_W-1:0] m_user_q;
  logic                   load_out;

  // Shared arithmetic units
  logic                 mul_start, mul_done;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    mul_prod;
  logic                 div_start, div_done;
  logic [DIV_CNT_W-1:0] div_steps;
  logic [DIV_D_W-1:0]   div_rem, div_den;
  logic [DIV_N_W-1:0]   div_num, div_quo;

  // Derived values
  logic                 in_fire, cfg_write;
  logic [TIME_W-1:0]    elapsed;
  logic                 ramp_done;
  logic [DUTY_W:0]      span, span_mag, diff, diff_mag;
  logic [NORM_W-1:0]    norm_sat;
  logic [FRAC_W-1:0]    t_frac;
  logic [NORM_W-1:0]    u_half, ease_op, ease_e;
  logic [DUTY_W-1:0]    prod_mag;
  logic signed [DUTY_W+1:0] target;
  logic [DUTY_W-1:0]    target_clamped;
  logic [LEN_W-1:0]     len_sel;
  logic [RES_W-1:0]     bits_sat;
  logic [COUNT_W-1:0]   res_top;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_write     = psel && penable && pwrite && pready;
  assign pready        = 1'b1;

  // Decode registers for reads
  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_MIN_DUTY: prdata = PDATA_W'(min_duty_q);
      REG_MAX_DUTY: prdata = PDATA_W'(max_duty_q);
      REG_RES_BITS: prdata = PDATA_W'(res_bits_q);
      REG_DEF_RAMP: prdata = PDATA_W'(def_ramp_q);
      default:      prdata = '0;
    endcase
  end

  // Ramp timing, spans and ease operands
  always_comb begin
    elapsed   = now_q - ramp_start_q;
    ramp_done = (elapsed >= TIME_W'(ramp_length_q));
    span      = {1'b0, max_duty_q} - {1'b0, min_duty_q};
    span_mag  = span[DUTY_W] ? ((DUTY_W+1)'(0) - span) : span;
    diff      = {1'b0, duty_goal_q} - {1'b0, duty_now_q};
    diff_mag  = diff[DUTY_W] ? ((DUTY_W+1)'(0) - diff) : diff;
    norm_sat  = (norm_q > ONE_Q) ? ONE_Q : norm_q;
    t_frac    = div_quo[FRAC_W-1:0];
    u_half    = ONE_Q - {1'b0, t_frac};
    ease_op   = t_frac[FRAC_W-1] ? {u_half[FRAC_W-1:0], 1'b0} : {1'b0, t_frac};
    // ease-in: 2*t*t, ease-out: 1 - (2*(1-t))^2 / 2
    ease_e    = ease_lo_q ? mul_prod[2*FRAC_W-1:FRAC_W-1]
                          : (ONE_Q - mul_prod[2*FRAC_W+1:FRAC_W+1]);
    prod_mag  = mul_prod[FRAC_W+DUTY_W-1:FRAC_W];
    target    = neg_q ? ($signed({2'b00, min_duty_q}) - $signed({2'b00, prod_mag}))
                      : ($signed({2'b00, min_duty_q}) + $signed({2'b00, prod_mag}));
    target_clamped = clamp_duty(target, min_duty_q, max_duty_q);
    if (!rms_q[RMS_W-1] && (rms_q[LEN_W-1:0] != '0)) begin
      len_sel = rms_q[LEN_W-1:0];
    end else begin
      len_sel = def_ramp_q;
    end
    if (res_bits_q == '0) begin
      bits_sat = RES_W'(1);
    end else if (res_bits_q > RES_W'(MAX_RES)) begin
      bits_sat = RES_W'(MAX_RES);
    end else begin
      bits_sat = res_bits_q;
    end
    res_top = COUNT_W'(((COUNT_W+1)'(1) << bits_sat) - (COUNT_W+1)'(1));
  end

  // Sequence one request through the serial units
  always_comb begin
    state_d       = state_q;
    duty_now_d    = duty_now_q;
    duty_goal_d   = duty_goal_q;
    ramp_start_d  = ramp_start_q;
    ramp_length_d = ramp_length_q;
    ramp_active_d = ramp_active_q;
    written_d     = written_q;
    neg_d         = neg_q;
    ease_lo_d     = ease_lo_q;
    count_d       = count_q;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_steps     = '0;
    div_rem       = '0;
    div_num       = '0;
    div_den       = '0;
    load_out      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          written_d = 1'b0;
          state_d   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (cmd_q)
          CMD_TICK: begin
            if (!ramp_active_q) begin
              state_d = ST_COUNT;
            end else if (ramp_done) begin
              duty_now_d    = clamp_duty({2'b00, duty_goal_q}, min_duty_q, max_duty_q);
              ramp_active_d = 1'b0;
              written_d     = 1'b1;
              state_d       = ST_COUNT;
            end else begin
              // t = elapsed * 2^F / length, elapsed < length
              div_start = 1'b1;
              div_steps = DIV_CNT_W'(FRAC_W);
              div_rem   = elapsed[LEN_W-1:0];
              div_num   = '0;
              div_den   = ramp_length_q;
              state_d   = ST_DIV_T;
            end
          end
          CMD_SET_VALUE: begin
            mul_start = 1'b1;
            mul_a     = span_mag;
            mul_b     = norm_sat;
            neg_d     = span[DUTY_W];
            state_d   = ST_MUL_V;
          end
          CMD_SET_DUTY: begin
            duty_now_d = clamp_duty({2'b00, req_q}, min_duty_q, max_duty_q);
            written_d  = 1'b1;
            state_d    = ST_COUNT;
          end
          CMD_STOP: begin
            duty_now_d = clamp_duty('0, min_duty_q, max_duty_q);
            written_d  = 1'b1;
            state_d    = ST_COUNT;
          end
          default: state_d = ST_COUNT;
        endcase
      end
      ST_DIV_T: begin
        if (div_done) begin
          ease_lo_d = !t_frac[FRAC_W-1];
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(ease_op);
          mul_b     = ease_op;
          state_d   = ST_MUL_E;
        end
      end
      ST_MUL_E: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = diff_mag;
          mul_b     = ease_e;
          neg_d     = diff[DUTY_W];
          state_d   = ST_MUL_S;
        end
      end
      ST_MUL_S: begin
        // Step toward the goal, truncated toward zero, not clamped
        if (mul_done) begin
          duty_now_d = neg_q ? (duty_now_q - prod_mag) : (duty_now_q + prod_mag);
          written_d  = 1'b1;
          state_d    = ST_COUNT;
        end
      end
      ST_MUL_V: begin
        if (mul_done) begin
          if (len_sel != '0) begin
            ramp_active_d = 1'b1;
            duty_goal_d   = target_clamped;
            ramp_start_d  = now_q;
            ramp_length_d = len_sel;
          end else begin
            duty_now_d = target_clamped;
            written_d  = 1'b1;
          end
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(duty_now_q);
        mul_b     = MUL_B_W'(res_top);
        state_d   = ST_MUL_C;
      end
      ST_MUL_C: begin
        // Drop the fraction bits, then divide by one hundred
        if (mul_done) begin
          div_start = 1'b1;
          div_steps = DIV_CNT_W'(DIV_N_W);
          div_rem   = '0;
          div_num   = mul_prod[FRAC_W+DIV_N_W-1:FRAC_W];
          div_den   = PCT_DEN;
          state_d   = ST_DIV_C;
        end
      end
      ST_DIV_C: begin
        if (div_done && (!m_valid_q || m_axis_tready)) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
        if (div_done) begin
          count_d = (div_quo[DIV_N_W-1:COUNT_W] != '0) ? '1 : div_quo[COUNT_W-1:0];
          if (m_valid_q && !m_axis_tready) begin
            state_d = ST_DIV_C;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result while the downstream side stalls: stay in ST_DIV_C
  // with count_q captured, retry load on the following cycles.
  logic pending_q;
  logic out_fire;
  assign out_fire = pending_q && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (state_q == ST_DIV_C && div_done && m_valid_q && !m_axis_tready) begin
      pending_q <= 1'b1;
    end else if (out_fire) begin
      pending_q <= 1'b0;
    end
  end

  // Control and duty state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      duty_now_q    <= '0;
      duty_goal_q   <= '0;
      ramp_start_q  <= '0;
      ramp_length_q <= '0;
      ramp_active_q <= 1'b0;
      m_valid_q     <= 1'b0;
      min_duty_q    <= '0;
      max_duty_q    <= DUTY_W'(100) << FRAC_W;
      res_bits_q    <= RES_W'(10);
      def_ramp_q    <= '0;
    end else begin
      if (pending_q) begin
        state_q <= out_fire ? ST_IDLE : ST_DIV_C;
      end else if (state_q == ST_DIV_C && div_done && m_valid_q && !m_axis_tready) begin
        state_q <= ST_DIV_C;
      end else begin
        state_q <= state_d;
      end
      duty_now_q    <= duty_now_d;
      duty_goal_q   <= duty_goal_d;
      ramp_start_q  <= ramp_start_d;
      ramp_length_q <= ramp_length_d;
      ramp_active_q <= ramp_active_d;
      if (load_out || out_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_write) begin
        unique case (reg_e'(paddr[3:2]))
          REG_MIN_DUTY: min_duty_q <= pwdata[DUTY_W-1:0];
          REG_MAX_DUTY: max_duty_q <= pwdata[DUTY_W-1:0];
          REG_RES_BITS: res_bits_q <= pwdata[RES_W-1:0];
          REG_DEF_RAMP: def_ramp_q <= pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Capture the request and work values
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= cmd_e'(s_axis_tuser[1:0]);
      norm_q <= s_axis_tdata[16:0];
      req_q  <= s_axis_tdata[39:17];
      rms_q  <= s_axis_tdata[56:40];
      now_q  <= s_axis_tdata[88:57];
    end
    written_q <= written_d;
    neg_q     <= neg_d;
    ease_lo_q <= ease_lo_d;
    count_q   <= count_d;
    if (load_out) begin
      m_data_q <= {ramp_active_q, duty_now_q, count_d};
      m_user_q <= {written_q, 1'b1};
    end else if (out_fire) begin
      m_data_q <= {ramp_active_q, duty_now_q, count_q};
      m_user_q <= {written_q, 1'b1};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  epdr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  epdr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .steps_i (div_steps),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_ramp_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_active_q |-> (ramp_length_q != '0))
    else $error("active ramp with zero length");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_DISPATCH))
    else $error("accepted request not dispatched");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL_E || state_q == ST_MUL_S ||
                  state_q == ST_MUL_V || state_q == ST_MUL_C))
    else $error("multiplier finished outside a multiply state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_T || state_q == ST_DIV_C))
    else $error("divider finished outside a divide state");
`endif

endmodule

/* sim/tb.sv */
// Self-checking testbench for the eased PWM duty ramp unit.
`timescale 1ns / 100ps

module tb;
  import epdr_pkg::*;

  localparam int     RUN_LIMIT     = 1000000;
  localparam int     SETTLE_CYCLES = 128;
  localparam int     HOLD_CYCLES   = 1500;
  localparam int     PRINT_CAP     = 40;
  localparam longint DUTY_MASK     = 64'h7F_FFFF;
  localparam longint ONE_FRAC      = 64'd1 << FRAC_W;
  localparam longint PCT_FULL      = 64'd100 << FRAC_W;

  // One PWM report as the block returns it
  typedef struct packed {
    logic               accepted;
    logic               written;
    logic [COUNT_W-1:0] count;
    logic [DUTY_W-1:0]  duty;
    logic               ramping;
  } duty_report_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
  logic [TUSER_IN_W-1:0]  s_axis_tuser  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic [TUSER_OUT_W-1:0] m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [PADDR_W-1:0]     paddr         = '0;
  logic [PDATA_W-1:0]     pwdata        = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  // Register mirror, reset values
  longint cfg_min_duty = 0;
  longint cfg_max_duty = 6553600;
  longint cfg_res_bits = 10;
  longint cfg_def_ramp = 0;

  // Duty and ramp state of the predictor
  longint      pred_duty    = 0;
  longint      pred_goal    = 0;
  logic [31:0] pred_start   = '0;
  longint      pred_len     = 0;
  bit          pred_ramping = 1'b0;

  duty_report_t duty_reports_q[$];
  int           mismatch_count = 0;
  int           requests_sent  = 0;
  int           burst_left     = 0;
  bit           hold_request   = 1'b0;
  logic [31:0]  wall_ms        = '0;
  int unsigned  cycle_count;

  eased_pwm_duty_ramp_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------- predictor

  // Hold a duty inside min..max; if the bounds cross, below min gives min, else max
  function automatic longint duty_clamp(input longint x);
    if (x < cfg_min_duty) return cfg_min_duty;
    if (x > cfg_max_duty) return cfg_max_duty;
    return x;
  endfunction

  // Scale a duty percent to a compare count at the current resolution
  function automatic longint pct_to_count(input longint duty);
    longint bits;
    longint c;
    bits = cfg_res_bits;
    if (bits < 1) bits = 1;
    if (bits > MAX_RES) bits = MAX_RES;
    c = (duty * ((64'd1 << bits) - 1)) / PCT_FULL;
    if (c > 65535) c = 65535;
    return c;
  endfunction

  // Ease-in-out quadratic on a fraction in Q.FRAC_W
  function automatic longint ease_in_out(input longint t);
    longint u;
    if (t < (ONE_FRAC >> 1)) return (2 * t * t) >> FRAC_W;
    u = 2 * (ONE_FRAC - t);
    return ONE_FRAC - ((u * u) >> (FRAC_W + 1));
  endfunction

  // Advance the duty state by one request and queue the report it causes
  function automatic void predict_report(input cmd_e cmd, input logic [NORM_W-1:0] norm,
                                         input logic [DUTY_W-1:0] duty_req,
                                         input logic signed [RMS_W-1:0] rms,
                                         input logic [TIME_W-1:0] now);
    duty_report_t rep;
    logic [31:0]  elapsed;
    longint       el_l, frac, step, n, target, len;
    rep.written = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (pred_ramping) begin
          elapsed = now - pred_start;
          el_l    = elapsed;
          if (el_l >= pred_len) begin
            pred_duty    = duty_clamp(pred_goal);
            pred_ramping = 1'b0;
          end else begin
            frac      = (el_l << FRAC_W) / pred_len;
            step      = (ease_in_out(frac) * (pred_goal - pred_duty)) / ONE_FRAC;
            pred_duty = (pred_duty + step) & DUTY_MASK;
          end
          rep.written = 1'b1;
        end
      end
      CMD_SET_VALUE: begin
        n = norm;
        if (n > ONE_FRAC) n = ONE_FRAC;
        target = cfg_min_duty + (n * (cfg_max_duty - cfg_min_duty)) / ONE_FRAC;
        len = rms;
        if (len <= 0) len = cfg_def_ramp;
        if (len > 0) begin
          pred_ramping = 1'b1;
          pred_goal    = duty_clamp(target);
          pred_start   = now;
          pred_len     = len & 64'hFFFF;
        end else begin
          pred_duty   = duty_clamp(target);
          rep.written = 1'b1;
        end
      end
      CMD_SET_DUTY: begin
        pred_duty   = duty_clamp(duty_req);
        rep.written = 1'b1;
      end
      CMD_STOP: begin
        pred_duty   = duty_clamp(0);
        rep.written = 1'b1;
      end
    endcase
    rep.accepted = 1'b1;
    rep.count    = pct_to_count(pred_duty);
    rep.duty     = pred_duty[DUTY_W-1:0];
    rep.ramping  = pred_ramping;
    duty_reports_q.push_back(rep);
  endfunction

  // ------------------------------------------------------------------- drivers

  // Offer one request, idling between bursts, and predict it once taken
  task automatic send_request(input cmd_e cmd, input logic [NORM_W-1:0] norm,
                              input logic [DUTY_W-1:0] duty_req,
                              input logic signed [RMS_W-1:0] rms,
                              input logic [TIME_W-1:0] now);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, now, rms, duty_req, norm};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
    predict_report(cmd, norm, duty_req, rms, now);
  endtask

  // Write one register through setup and access phases
  task automatic write_reg(input reg_e idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MIN_DUTY: cfg_min_duty = value & DUTY_MASK;
      REG_MAX_DUTY: cfg_max_duty = value & DUTY_MASK;
      REG_RES_BITS: cfg_res_bits = value & 32'h1F;
      REG_DEF_RAMP: cfg_def_ramp = value & 32'hFFFF;
    endcase
  endtask

  // Drop valid, wait for every pending report, then let the block go quiet
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (duty_reports_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ------------------------------------------------------------------ receiver

  // Stall on a rotating random pattern; hold off for a long stretch on demand
  initial begin : report_sink
    int          phase_left;
    int          hold_count;
    logic [31:0] stall_pat;
    bit          always_ready;
    phase_left   = 0;
    stall_pat    = '1;
    always_ready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk_i);
      end else begin
        if (phase_left == 0) begin
          phase_left   = $urandom_range(16, 96);
          always_ready = ($urandom_range(0, 2) == 0);
          stall_pat    = $urandom | $urandom;
        end
        phase_left--;
        m_axis_tready <= always_ready | stall_pat[phase_left % 32];
      end
    end
  end

  // ------------------------------------------------------------------- checker

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Compare each returned report with the oldest prediction
  always @(posedge clk_i) begin : check_reports
    duty_report_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.accepted = m_axis_tuser[0];
      got.written  = m_axis_tuser[1];
      got.count    = m_axis_tdata[15:0];
      got.duty     = m_axis_tdata[38:16];
      got.ramping  = m_axis_tdata[39];
      if (duty_reports_q.size() == 0) begin
        report_mismatch("report with no request pending, duty", -1, got.duty);
      end else begin
        want = duty_reports_q.pop_front();
        if (got.accepted !== want.accepted) report_mismatch("accepted", want.accepted, got.accepted);
        if (got.written !== want.written) report_mismatch("duty_written", want.written, got.written);
        if (got.count !== want.count) report_mismatch("duty_count", want.count, got.count);
        if (got.duty !== want.duty) report_mismatch("current_duty", want.duty, got.duty);
        if (got.ramping !== want.ramping) report_mismatch("ramping", want.ramping, got.ramping);
      end
    end
  end

  // ------------------------------------------------------------ random helpers

  function automatic logic [NORM_W-1:0] pick_norm();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return NORM_W'(ONE_FRAC);
      2:       return NORM_W'($urandom_range(65537, 131071));
      default: return NORM_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [DUTY_W-1:0] pick_duty();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return DUTY_W'(6553600);
      2:       return DUTY_W'($urandom_range(6553601, 8388607));
      default: return DUTY_W'($urandom_range(0, 6553600));
    endcase
  endfunction

  // Start a ramp, tick through it with random steps, interrupt now and then
  task automatic run_ramp_sequence();
    int                      len, eff_len, n_ticks, i;
    logic signed [RMS_W-1:0] rms;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: len = $urandom_range(1, 64);
      6, 7:             len = $urandom_range(65, 3000);
      8:                len = $urandom_range(3001, 65535);
      default:          len = 0;
    endcase
    rms     = (len > 0) ? RMS_W'(len) : RMS_W'(-$urandom_range(0, 65536));
    eff_len = (len > 0) ? len : int'(cfg_def_ramp);
    send_request(CMD_SET_VALUE, pick_norm(), DUTY_W'($urandom), rms, wall_ms);
    n_ticks = $urandom_range(1, 8);
    for (i = 0; i < n_ticks; i++) begin
      case ($urandom_range(0, 19))
        0: send_request(CMD_SET_DUTY, NORM_W'($urandom), pick_duty(), RMS_W'($urandom), $urandom);
        1: send_request(CMD_STOP, NORM_W'($urandom), DUTY_W'($urandom), RMS_W'($urandom), $urandom);
        2: send_request(CMD_SET_VALUE, pick_norm(), DUTY_W'($urandom),
                        RMS_W'($urandom_range(1, 80)), wall_ms);
        default: begin
          wall_ms += $urandom_range(0, (eff_len * 2) / n_ticks + 1);
          send_request(CMD_TICK, NORM_W'($urandom), DUTY_W'($urandom), RMS_W'($urandom), wall_ms);
        end
      endcase
    end
    // Run past the end of the ramp most of the time
    if ($urandom_range(0, 9) < 7) begin
      wall_ms += eff_len + $urandom_range(0, 3);
      send_request(CMD_TICK, NORM_W'($urandom), DUTY_W'($urandom), RMS_W'($urandom), wall_ms);
    end
  endtask

  task automatic send_noise();
    send_request(cmd_e'($urandom_range(0, 3)), NORM_W'($urandom), DUTY_W'($urandom),
                 RMS_W'($urandom), $urandom);
  endtask

  task automatic write_random_config();
    logic [DUTY_W-1:0] lo, hi, tmp;
    lo = pick_duty();
    hi = pick_duty();
    if ($urandom_range(0, 3) != 0 && lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    write_reg(REG_MIN_DUTY, lo);
    write_reg(REG_MAX_DUTY, hi);
    case ($urandom_range(0, 7))
      0:       write_reg(REG_RES_BITS, 0);
      1:       write_reg(REG_RES_BITS, 31);
      2:       write_reg(REG_RES_BITS, MAX_RES);
      3:       write_reg(REG_RES_BITS, 1);
      default: write_reg(REG_RES_BITS, $urandom_range(1, MAX_RES));
    endcase
    case ($urandom_range(0, 5))
      0, 1:    write_reg(REG_DEF_RAMP, 0);
      2:       write_reg(REG_DEF_RAMP, 65535);
      default: write_reg(REG_DEF_RAMP, $urandom_range(1, 100));
    endcase
  endtask

  // --------------------------------------------------------------------- tests

  // Immediate commands and idle ticks under the reset settings
  task automatic test_commands();
    send_request(CMD_STOP, 0, 0, 0, 0);
    send_request(CMD_SET_DUTY, 0, 6553600, 0, 0);
    send_request(CMD_SET_DUTY, 0, 23'h7F_FFFF, 0, 0);
    send_request(CMD_SET_DUTY, 0, 0, 0, 0);
    send_request(CMD_SET_DUTY, 0, 3276800, 0, 0);
    send_request(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF);
    send_request(CMD_SET_VALUE, 0, 0, 0, 0);
    send_request(CMD_SET_VALUE, 17'h1_0000, 0, -1, 0);
    // value above one saturates; most negative ramp field picks the default
    send_request(CMD_SET_VALUE, 17'h1_FFFF, 0, 17'h1_0000, 0);
    send_request(CMD_SET_VALUE, 32768, 0, 0, 0);
  endtask

  // Eased ramps: both halves of the curve, interruptions, time wrap, snap
  task automatic test_eased_ramp();
    send_request(CMD_SET_VALUE, 17'h1_0000, 0, 100, 1000);
    send_request(CMD_TICK, 0, 0, 0, 1000);
    send_request(CMD_TICK, 0, 0, 0, 1020);
    send_request(CMD_TICK, 0, 0, 0, 1050);
    send_request(CMD_TICK, 0, 0, 0, 1080);
    // immediate set while ramping keeps the ramp alive
    send_request(CMD_SET_DUTY, 0, 1000000, 0, 1085);
    send_request(CMD_TICK, 0, 0, 0, 1090);
    send_request(CMD_TICK, 0, 0, 0, 1100);
    send_request(CMD_SET_VALUE, 0, 0, 65535, 32'hFFFF_FFF0);
    send_request(CMD_TICK, 0, 0, 0, 32'h0000_0010);
    send_request(CMD_TICK, 0, 0, 0, 32'h0001_0000);
    send_request(CMD_SET_VALUE, 40000, 0, 50, 5000);
    send_request(CMD_STOP, 0, 0, 0, 5010);
    send_request(CMD_TICK, 0, 0, 0, 5020);
    send_request(CMD_TICK, 0, 0, 0, 5060);
  endtask

  // Crossed bounds, bounds above full scale, resolution saturation
  task automatic test_register_extremes();
    drain_results();
    write_reg(REG_MIN_DUTY, 6553600);
    write_reg(REG_MAX_DUTY, 0);
    write_reg(REG_RES_BITS, 0);
    write_reg(REG_DEF_RAMP, 0);
    send_request(CMD_SET_VALUE, 32768, 0, 0, 0);
    send_request(CMD_SET_DUTY, 0, 0, 0, 0);
    send_request(CMD_STOP, 0, 0, 0, 0);
    send_request(CMD_SET_DUTY, 0, 23'h7F_FFFF, 0, 0);
    drain_results();
    write_reg(REG_MIN_DUTY, 23'h7F_FFFF);
    write_reg(REG_MAX_DUTY, 23'h7F_FFFF);
    write_reg(REG_RES_BITS, 31);
    send_request(CMD_SET_DUTY, 0, 0, 0, 0);
    send_request(CMD_SET_VALUE, 17'h1_0000, 0, 0, 0);
    drain_results();
    write_reg(REG_MIN_DUTY, 0);
    write_reg(REG_MAX_DUTY, 6553600);
    write_reg(REG_RES_BITS, MAX_RES);
    send_request(CMD_SET_DUTY, 0, 6553600, 0, 0);
    send_request(CMD_SET_VALUE, 65535, 0, 0, 0);
    drain_results();
    write_reg(REG_RES_BITS, 1);
    send_request(CMD_SET_DUTY, 0, 6553600, 0, 0);
    send_request(CMD_SET_DUTY, 0, 3276799, 0, 0);
  endtask

  // Ramps whose length comes from the default register
  task automatic test_default_ramp();
    drain_results();
    write_reg(REG_MIN_DUTY, 655360);
    write_reg(REG_MAX_DUTY, 5898240);
    write_reg(REG_RES_BITS, 12);
    write_reg(REG_DEF_RAMP, 40);
    send_request(CMD_SET_VALUE, 50000, 0, 0, 200);
    send_request(CMD_TICK, 0, 0, 0, 210);
    send_request(CMD_TICK, 0, 0, 0, 230);
    send_request(CMD_SET_VALUE, 10000, 0, -5, 240);
    send_request(CMD_TICK, 0, 0, 0, 250);
    send_request(CMD_TICK, 0, 0, 0, 300);
    drain_results();
    write_reg(REG_DEF_RAMP, 65535);
    send_request(CMD_SET_VALUE, 17'h1_0000, 0, -1, 0);
    send_request(CMD_TICK, 0, 0, 0, 30000);
    send_request(CMD_TICK, 0, 0, 0, 65535);
  endtask

  // Block the report side for a long stretch while requests keep coming
  task automatic test_output_stall();
    drain_results();
    wall_ms      = $urandom;
    hold_request = 1'b1;
    repeat (3) run_ramp_sequence();
  endtask

  // Random traffic over several register settings
  task automatic test_random_phases();
    int phase, phase_end;
    for (phase = 0; phase < 8; phase++) begin
      drain_results();
      write_random_config();
      wall_ms   = $urandom;
      phase_end = requests_sent + 40;
      while (requests_sent < phase_end) begin
        if ($urandom_range(0, 9) < 7) run_ramp_sequence();
        else send_noise();
      end
    end
  endtask

  initial begin : regression
    wait (rst_ni);
    @(posedge clk_i);
    test_commands();
    test_eased_ramp();
    test_register_extremes();
    test_default_ramp();
    test_output_stall();
    test_random_phases();
    drain_results();
    if (mismatch_count == 0) begin
      $display("eased_pwm_duty_ramp_unit regression: pass");
    end else begin
      $display("eased_pwm_duty_ramp_unit regression: fail");
    end
    $finish;
  end

  // Abort a hung run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("eased_pwm_duty_ramp_unit regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/epdr_pkg.sv
rtl/core/epdr_mul.sv
rtl/core/epdr_div.sv
rtl/core/eased_pwm_duty_ramp_unit.sv
sim/tb.sv
